// ===== sv/khc_pkg.sv =====
// Package for the k-ary Huffman cost block: widths, types and state codes.
`timescale 1ns / 1ps
package khc_pkg;
	localparam int W_WIDTH = 32;
	localparam int C_WIDTH = 44;
	localparam int K_WIDTH = 7;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_SORT_RD,
		ST_SORT_V,
		ST_SORT_CMP,
		ST_K_INIT,
		ST_R_SUB,
		ST_NODE_TEST,
		ST_DEC_RD,
		ST_DEC,
		ST_SUM,
		ST_NODE_END,
		ST_EMIT
	} state_t;
endpackage

// ===== sv/kary_huffman_cost_all_arities_top.sv =====
// Top level of the k-ary Huffman merge cost engine.
//
// Usage: weights stream in on s_axis (tdata = weight, tlast marks the last
// weight of the set), one transaction per cycle while tready is high. The block
// holds up to MAX_WEIGHTS weights; extra weights are dropped, but tlast still
// starts the computation.
// After tlast the set is insertion-sorted in the weight memory (at most about
// n*n/2 shifts). Then for every arity k = 2..n the greedy two-queue merge runs
// on the weight memory and the merged-node memory (one read per memory per
// cycle): each node takes smaller merged nodes in place of the largest sorted
// candidates, sums its sorted weights and is written to the merged-node memory.
// One result per arity leaves on m_axis; tlast marks k = n.
// A set of one weight gives no result and the input stays ready.
// tready is low from the tlast transaction until the last result of the set
// is in the output register.
// Reset clears the control state and the output valid; the memories are not
// cleared, every entry is written before its value is used.
// If the receiver stalls, the result register holds and the sequencer waits.
`timescale 1ns / 1ps
module kary_huffman_cost_all_arities_top #(
	parameter int MAX_WEIGHTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] weight
	input  logic        s_axis_tlast,   // final_item
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,   // [6:0] arity, [50:7] total_cost, pad
	output logic        m_axis_tlast    // end_of_run
);
	import khc_pkg::*;

	localparam int AW = (MAX_WEIGHTS > 1) ? $clog2(MAX_WEIGHTS) : 1;  // memory index
	localparam int IW = $clog2(2 * MAX_WEIGHTS + 2);                  // counters

	// memories
	logic [W_WIDTH-1:0] wmem [MAX_WEIGHTS];
	logic [C_WIDTH-1:0] qmem [MAX_WEIGHTS];

	state_t state_q, state_d;
	logic [IW-1:0] n_q, n_ld;
	logic [IW-1:0] p_q, q_q;       // sort indices, sum index
	logic [W_WIDTH-1:0] v_q;       // value being inserted
	logic [K_WIDTH-1:0] k_q;
	logic [IW-1:0] km1;
	logic [IW-1:0] pos_q, start_q, head_q, cnt_q, r_q;
	logic [C_WIDTH-1:0] node_q, total_q;
	logic sv_q;                    // wrd_q holds a weight to add
	logic [W_WIDTH-1:0] wrd_q, w_wd;
	logic [C_WIDTH-1:0] qrd_q, q_wd;
	logic [AW-1:0] w_ra, w_wa, q_ra, q_wa;
	logic w_we, q_we;
	logic sort_shift, sort_done, node_go, dec_take, out_load;
	logic out_v_q;
	logic [K_WIDTH-1:0] out_k_q;
	logic [C_WIDTH-1:0] out_c_q;
	logic out_l_q;

	assign s_axis_tready = (state_q == ST_LOAD);
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {5'd0, out_c_q, out_k_q};
	assign m_axis_tlast  = out_l_q;

	// decisions shared by the sequencer and the datapath
	assign n_ld       = (n_q < IW'(MAX_WEIGHTS)) ? n_q + 1'b1 : n_q;
	assign km1        = IW'(k_q) - 1'b1;
	assign sort_shift = (q_q != '0) && (wrd_q > v_q);
	assign sort_done  = (p_q + 1'b1 >= n_q);
	assign node_go    = (pos_q + head_q < n_q + cnt_q) && (cnt_q < IW'(MAX_WEIGHTS));
	assign dec_take   = (head_q <= cnt_q) && (pos_q > start_q) &&
		((pos_q > n_q) || (qrd_q < C_WIDTH'(wrd_q)));
	assign out_load   = (state_q == ST_EMIT) && (!out_v_q || m_axis_tready);

	// next state and memory control
	always_comb begin
		state_d = state_q;
		w_ra = '0; w_we = 1'b0; w_wa = '0; w_wd = '0;
		q_ra = '0; q_we = 1'b0; q_wa = '0; q_wd = '0;
		case (state_q)
			ST_LOAD: begin
				if (s_axis_tvalid) begin
					if (n_q < IW'(MAX_WEIGHTS)) begin
						w_we = 1'b1;
						w_wa = AW'(n_q);
						w_wd = s_axis_tdata;
					end
					if (s_axis_tlast && n_ld > IW'(1)) state_d = ST_SORT_RD;
				end
			end
			ST_SORT_RD: begin
				w_ra = AW'(p_q);
				state_d = ST_SORT_V;
			end
			ST_SORT_V: begin
				w_ra = AW'(q_q - 1'b1);
				state_d = ST_SORT_CMP;
			end
			ST_SORT_CMP: begin
				w_we = 1'b1;
				w_wa = AW'(q_q);
				if (sort_shift) begin
					w_wd = wrd_q;
					if (q_q > IW'(1)) w_ra = AW'(q_q - 2'd2);
				end else begin
					w_wd = v_q;
					state_d = sort_done ? ST_K_INIT : ST_SORT_RD;
				end
			end
			ST_K_INIT: state_d = ST_R_SUB;
			ST_R_SUB: begin
				if (r_q < km1) state_d = (r_q != '0) ? ST_SUM : ST_NODE_TEST;
			end
			ST_NODE_TEST: state_d = node_go ? ST_DEC_RD : ST_EMIT;
			ST_DEC_RD: begin
				if (pos_q != '0 && pos_q <= n_q) w_ra = AW'(pos_q - 1'b1);
				if (head_q <= cnt_q) q_ra = AW'(head_q - 1'b1);
				state_d = ST_DEC;
			end
			ST_DEC: state_d = dec_take ? ST_DEC_RD : ST_SUM;
			ST_SUM: begin
				if (p_q < pos_q) w_ra = AW'(p_q);
				else if (!sv_q) state_d = ST_NODE_END;
			end
			ST_NODE_END: begin
				q_we = 1'b1;
				q_wa = AW'(cnt_q);
				q_wd = node_q;
				state_d = ST_NODE_TEST;
			end
			ST_EMIT: begin
				if (out_load) state_d = (IW'(k_q) == n_q) ? ST_LOAD : ST_K_INIT;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// weight memory, registered read
	always_ff @(posedge clk) begin
		if (w_we) wmem[w_wa] <= w_wd;
		wrd_q <= wmem[w_ra];
	end

	// merged-node memory, registered read
	always_ff @(posedge clk) begin
		if (q_we) qmem[q_wa] <= q_wd;
		qrd_q <= qmem[q_ra];
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_LOAD;
		else state_q <= state_d;
	end

	// datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
			p_q <= '0;
			q_q <= '0;
			v_q <= '0;
			k_q <= '0;
			r_q <= '0;
			pos_q <= '0;
			start_q <= '0;
			head_q <= '0;
			cnt_q <= '0;
			node_q <= '0;
			total_q <= '0;
			sv_q <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (s_axis_tvalid) begin
						if (s_axis_tlast) begin
							n_q <= (n_ld > IW'(1)) ? n_ld : '0;
							p_q <= IW'(1);
						end else n_q <= n_ld;
					end
				end
				ST_SORT_RD: q_q <= p_q;
				ST_SORT_V: v_q <= wrd_q;
				ST_SORT_CMP: begin
					if (sort_shift) q_q <= q_q - 1'b1;
					else if (sort_done) k_q <= K_WIDTH'(2);
					else p_q <= p_q + 1'b1;
				end
				// r = (n-1) mod (k-1) by repeated subtraction
				ST_K_INIT: r_q <= n_q - 1'b1;
				ST_R_SUB: begin
					if (r_q >= km1) r_q <= r_q - km1;
					else begin
						// partial first merge sums the smallest r+1 weights
						head_q <= IW'(1);
						cnt_q <= '0;
						total_q <= '0;
						node_q <= '0;
						start_q <= '0;
						p_q <= '0;
						sv_q <= 1'b0;
						pos_q <= (r_q != '0) ? r_q + 1'b1 : '0;
					end
				end
				ST_NODE_TEST: begin
					if (node_go) begin
						start_q <= pos_q;
						pos_q <= pos_q + IW'(k_q);
						node_q <= '0;
					end
				end
				// swap the largest sorted candidate for a smaller merged node
				ST_DEC: begin
					if (dec_take) begin
						node_q <= node_q + qrd_q;
						pos_q <= pos_q - 1'b1;
						head_q <= head_q + 1'b1;
					end else begin
						pos_q <= (pos_q > n_q) ? n_q : pos_q;
						p_q <= start_q;
						sv_q <= 1'b0;
					end
				end
				// add sorted weights start..pos-1, one read per cycle
				ST_SUM: begin
					if (sv_q) node_q <= node_q + C_WIDTH'(wrd_q);
					sv_q <= (p_q < pos_q);
					if (p_q < pos_q) p_q <= p_q + 1'b1;
				end
				ST_NODE_END: begin
					cnt_q <= cnt_q + 1'b1;
					total_q <= total_q + node_q;
				end
				ST_EMIT: begin
					if (out_load) begin
						if (IW'(k_q) == n_q) n_q <= '0;
						else k_q <= k_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			out_k_q <= '0;
			out_c_q <= '0;
			out_l_q <= 1'b0;
		end else if (out_load) begin
			out_v_q <= 1'b1;
			out_k_q <= k_q;
			out_c_q <= total_q;
			out_l_q <= (IW'(k_q) == n_q);
		end else if (m_axis_tready) begin
			out_v_q <= 1'b0;
		end
	end
endmodule

// ===== sv/khc_checker.sv =====
// Port-level checker for the k-ary Huffman cost block and its bind.
`timescale 1ns / 1ps
module khc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [55:0] m_axis_tdata,
	input logic        m_axis_tlast
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready || m_axis_tlast)
		else $error("input open while a non-final result waits");
	a_arity: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[6:0] >= 7'd2)
		else $error("arity below two");
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[55:51] == 5'd0)
		else $error("padding bits set");
endmodule

bind kary_huffman_cost_all_arities_top khc_checker u_khc_checker (.*);
